@@ rtl/bceu_pkg.sv @@
`default_nettype none

package bceu_pkg;

    localparam int KIND_W = 5;
    localparam int WORD_W = 64;
    localparam int TRAP_W = 2;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [TRAP_W-1:0] trap_t;

    // Operation codes.
    localparam kind_t KIND_JMP     = 5'd0;
    localparam kind_t KIND_JSR     = 5'd1;
    localparam kind_t KIND_JMPF    = 5'd2;
    localparam kind_t KIND_JSRF    = 5'd3;
    localparam kind_t KIND_BRA     = 5'd4;
    localparam kind_t KIND_BRT     = 5'd5;
    localparam kind_t KIND_BRF     = 5'd6;
    localparam kind_t KIND_TRAP_UD = 5'd7;
    localparam kind_t KIND_NOP     = 5'd8;
    localparam kind_t KIND_RTS     = 5'd9;
    localparam kind_t KIND_SLEEP   = 5'd10;
    localparam kind_t KIND_RTE     = 5'd11;
    localparam kind_t KIND_BREAK   = 5'd12;
    localparam kind_t KIND_SYNCO   = 5'd13;
    localparam kind_t KIND_SYNCI   = 5'd14;
    localparam kind_t KIND_BRAOT   = 5'd15;
    localparam kind_t KIND_BSROT   = 5'd16;

    // Trap status codes.
    localparam trap_t TRAP_NONE  = 2'd0;
    localparam trap_t TRAP_UD    = 2'd1;
    localparam trap_t TRAP_SLEEP = 2'd2;
    localparam trap_t TRAP_BREAK = 2'd3;

    // Size of one instruction, added for link values and relative jumps.
    localparam word_t INSTR_BYTES = 64'd2;

    typedef struct packed {
        logic  pc_write;
        word_t next_pc;
        logic  lr_write;
        word_t next_lr;
        logic  sr_write;
        word_t next_sr;
        logic  sp_write;
        word_t next_sp;
        trap_t trap_status;
        logic  flush_request;
        logic  end_trace;
        word_t table_address;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/branch_control_execute_unit.sv @@
`default_nettype none

// Branch and system instruction execute unit.
//
// The input channel (s_*) carries one control-flow or system instruction per
// transfer, together with every register value the operation may read and the
// qword fetched from the offset table. The result channel (m_*) returns one
// result per instruction: write enables and values for PC, LR, SR and SP, a
// trap code, a flush request, an end-of-trace flag and the table address.
//
// The unit has two register stages: an input register and a result register,
// with the adders and selection between them. An accepted transfer is held in
// the input register, then in the result register, which drives the m_ ports.
// One transfer per cycle is sustained while m_ready stays high; both stages
// advance together whenever the result register is empty or being drained.
//
// When the receiver holds m_ready low, the result register keeps its value,
// the input register fills, and s_ready drops once both stages are occupied.
// Nothing is dropped or duplicated. Synchronous reset (aresetn low) empties
// both stages; the unit keeps no architectural state.
module branch_control_execute_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bceu_pkg::kind_t   s_kind,
    input  wire bceu_pkg::word_t   s_instr_pc,
    input  wire bceu_pkg::word_t   s_rm_value,
    input  wire bceu_pkg::word_t   s_immediate,
    input  wire bceu_pkg::word_t   s_sr_value,
    input  wire bceu_pkg::word_t   s_lr_value,
    input  wire bceu_pkg::word_t   s_saved_pc,
    input  wire bceu_pkg::word_t   s_saved_sr,
    input  wire bceu_pkg::word_t   s_saved_sp,
    input  wire bceu_pkg::word_t   s_table_base,
    input  wire bceu_pkg::word_t   s_table_word,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_pc_write,
    output bceu_pkg::word_t        m_next_pc,
    output logic                   m_lr_write,
    output bceu_pkg::word_t        m_next_lr,
    output logic                   m_sr_write,
    output bceu_pkg::word_t        m_next_sr,
    output logic                   m_sp_write,
    output bceu_pkg::word_t        m_next_sp,
    output bceu_pkg::trap_t        m_trap_status,
    output logic                   m_flush_request,
    output logic                   m_end_trace,
    output bceu_pkg::word_t        m_table_address
);
    import bceu_pkg::*;

    // Input stage registers.
    logic    in_valid_reg;
    kind_t   kind_reg;
    word_t   instr_pc_reg;
    word_t   rm_value_reg;
    word_t   immediate_reg;
    word_t   sr_value_reg;
    word_t   lr_value_reg;
    word_t   saved_pc_reg;
    word_t   saved_sr_reg;
    word_t   saved_sp_reg;
    word_t   table_base_reg;
    word_t   table_word_reg;

    // Result stage registers.
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic    out_load;
    logic    in_load;

    // The result register takes a new value when the input register is full and
    // it is empty or its current value is being transferred out in this cycle.
    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);

    // The input register can take a transfer when it is empty or its content
    // moves into the result register at the same edge.
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            kind_reg       <= s_kind;
            instr_pc_reg   <= s_instr_pc;
            rm_value_reg   <= s_rm_value;
            immediate_reg  <= s_immediate;
            sr_value_reg   <= s_sr_value;
            lr_value_reg   <= s_lr_value;
            saved_pc_reg   <= s_saved_pc;
            saved_sr_reg   <= s_saved_sr;
            saved_sp_reg   <= s_saved_sp;
            table_base_reg <= s_table_base;
            table_word_reg <= s_table_word;
        end
    end

    // Execute. Every field that is not written by the operation stays zero;
    // a conditional branch that is not taken produces an all-zero result.
    always_comb begin
        logic  t_flag;
        word_t link_value;
        word_t rel_target;
        word_t tbl_addr;

        t_flag      = sr_value_reg[0];
        link_value  = instr_pc_reg + INSTR_BYTES;
        rel_target  = link_value + rm_value_reg;
        tbl_addr    = table_base_reg + immediate_reg;
        result_next = '0;

        unique case (kind_reg)
            KIND_JMP: begin
                result_next.pc_write  = 1'b1;
                result_next.next_pc   = rm_value_reg;
                result_next.end_trace = 1'b1;
            end
            KIND_JSR: begin
                result_next.lr_write  = 1'b1;
                result_next.next_lr   = link_value;
                result_next.pc_write  = 1'b1;
                result_next.next_pc   = rm_value_reg;
                result_next.end_trace = 1'b1;
            end
            KIND_JMPF: begin
                result_next.pc_write  = 1'b1;
                result_next.next_pc   = rel_target;
                result_next.end_trace = 1'b1;
            end
            KIND_JSRF: begin
                result_next.lr_write  = 1'b1;
                result_next.next_lr   = link_value;
                result_next.pc_write  = 1'b1;
                result_next.next_pc   = rel_target;
                result_next.end_trace = 1'b1;
            end
            KIND_BRA: begin
                result_next.pc_write  = 1'b1;
                result_next.next_pc   = immediate_reg;
                result_next.end_trace = 1'b1;
            end
            KIND_BRT: begin
                if (t_flag) begin
                    result_next.pc_write  = 1'b1;
                    result_next.next_pc   = immediate_reg;
                    result_next.end_trace = 1'b1;
                end
            end
            KIND_BRF: begin
                if (!t_flag) begin
                    result_next.pc_write  = 1'b1;
                    result_next.next_pc   = immediate_reg;
                    result_next.end_trace = 1'b1;
                end
            end
            KIND_TRAP_UD: begin
                result_next.trap_status = TRAP_UD;
                result_next.end_trace   = 1'b1;
            end
            KIND_RTS: begin
                result_next.pc_write  = 1'b1;
                result_next.next_pc   = lr_value_reg;
                result_next.end_trace = 1'b1;
            end
            KIND_SLEEP: begin
                result_next.trap_status = TRAP_SLEEP;
                result_next.end_trace   = 1'b1;
            end
            KIND_RTE: begin
                result_next.sp_write  = 1'b1;
                result_next.next_sp   = saved_sp_reg;
                result_next.sr_write  = 1'b1;
                result_next.next_sr   = saved_sr_reg;
                result_next.pc_write  = 1'b1;
                result_next.next_pc   = saved_pc_reg;
                result_next.end_trace = 1'b1;
            end
            KIND_BREAK: begin
                result_next.trap_status = TRAP_BREAK;
                result_next.end_trace   = 1'b1;
            end
            KIND_SYNCI: begin
                // Flush request only; sequential flow continues.
                result_next.flush_request = 1'b1;
            end
            KIND_BRAOT: begin
                result_next.table_address = tbl_addr;
                result_next.pc_write      = 1'b1;
                result_next.next_pc       = table_word_reg;
                result_next.end_trace     = 1'b1;
            end
            KIND_BSROT: begin
                result_next.lr_write      = 1'b1;
                result_next.next_lr       = link_value;
                result_next.table_address = tbl_addr;
                result_next.pc_write      = 1'b1;
                result_next.next_pc       = table_word_reg;
                result_next.end_trace     = 1'b1;
            end
            // No-op, store barrier and unassigned codes give an empty result.
            default: begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pc_write      = result_reg.pc_write;
    assign m_next_pc       = result_reg.next_pc;
    assign m_lr_write      = result_reg.lr_write;
    assign m_next_lr       = result_reg.next_lr;
    assign m_sr_write      = result_reg.sr_write;
    assign m_next_sr       = result_reg.next_sr;
    assign m_sp_write      = result_reg.sp_write;
    assign m_next_sp       = result_reg.next_sp;
    assign m_trap_status   = result_reg.trap_status;
    assign m_flush_request = result_reg.flush_request;
    assign m_end_trace     = result_reg.end_trace;
    assign m_table_address = result_reg.table_address;

endmodule

`default_nettype wire

@@ bench/branch_control_execute_unit_tb.sv @@
`default_nettype none

module branch_control_execute_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bceu_pkg::*;

    // Cycles without any transfer on either channel before the run is given up.
    // The slowest correct case is a sender gap and a receiver stall on top of
    // the pipeline, so this is generous.
    localparam int STALL_LIMIT = 2000;

    // One instruction as it is presented on the input channel.
    typedef struct {
        kind_t kind;
        word_t instr_pc;
        word_t rm_value;
        word_t immediate;
        word_t sr_value;
        word_t lr_value;
        word_t saved_pc;
        word_t saved_sr;
        word_t saved_sp;
        word_t table_base;
        word_t table_word;
    } instr_t;

    logic  aclk;
    logic  aresetn;

    logic  s_valid;
    logic  s_ready;
    kind_t s_kind;
    word_t s_instr_pc;
    word_t s_rm_value;
    word_t s_immediate;
    word_t s_sr_value;
    word_t s_lr_value;
    word_t s_saved_pc;
    word_t s_saved_sr;
    word_t s_saved_sp;
    word_t s_table_base;
    word_t s_table_word;

    logic  m_valid;
    logic  m_ready;
    logic  m_pc_write;
    word_t m_next_pc;
    logic  m_lr_write;
    word_t m_next_lr;
    logic  m_sr_write;
    word_t m_next_sr;
    logic  m_sp_write;
    word_t m_next_sp;
    trap_t m_trap_status;
    logic  m_flush_request;
    logic  m_end_trace;
    word_t m_table_address;

    // Results predicted for accepted instructions, oldest first.
    result_t pending_results[$];
    int      mismatches;
    int      idle_cycles;
    // When set, the receiver stops stalling so the final stretch runs at full rate.
    bit      quiet;

    branch_control_execute_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_instr_pc      (s_instr_pc),
        .s_rm_value      (s_rm_value),
        .s_immediate     (s_immediate),
        .s_sr_value      (s_sr_value),
        .s_lr_value      (s_lr_value),
        .s_saved_pc      (s_saved_pc),
        .s_saved_sr      (s_saved_sr),
        .s_saved_sp      (s_saved_sp),
        .s_table_base    (s_table_base),
        .s_table_word    (s_table_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pc_write      (m_pc_write),
        .m_next_pc       (m_next_pc),
        .m_lr_write      (m_lr_write),
        .m_next_lr       (m_next_lr),
        .m_sr_write      (m_sr_write),
        .m_next_sr       (m_next_sr),
        .m_sp_write      (m_sp_write),
        .m_next_sp       (m_next_sp),
        .m_trap_status   (m_trap_status),
        .m_flush_request (m_flush_request),
        .m_end_trace     (m_end_trace),
        .m_table_address (m_table_address)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Expected result of one instruction. A taken control transfer writes the
    // PC and ends the trace; every value field whose write flag stays low is
    // zero, and the table address is only presented by the table jumps.
    function automatic result_t predict_branch(instr_t it);
        result_t r;
        logic    taken;
        logic    link;
        word_t   target;
        r      = '0;
        taken  = 1'b0;
        link   = 1'b0;
        target = '0;
        case (it.kind)
            KIND_JMP: begin
                taken  = 1'b1;
                target = it.rm_value;
            end
            KIND_JSR: begin
                taken  = 1'b1;
                link   = 1'b1;
                target = it.rm_value;
            end
            KIND_JMPF: begin
                taken  = 1'b1;
                target = it.instr_pc + INSTR_BYTES + it.rm_value;
            end
            KIND_JSRF: begin
                taken  = 1'b1;
                link   = 1'b1;
                target = it.instr_pc + INSTR_BYTES + it.rm_value;
            end
            KIND_BRA: begin
                taken  = 1'b1;
                target = it.immediate;
            end
            // Conditional branches test the T flag in bit 0 of SR; when not
            // taken, the whole result stays zero.
            KIND_BRT: begin
                taken  = it.sr_value[0];
                target = it.immediate;
            end
            KIND_BRF: begin
                taken  = ~it.sr_value[0];
                target = it.immediate;
            end
            KIND_TRAP_UD: begin
                r.trap_status = TRAP_UD;
                r.end_trace   = 1'b1;
            end
            KIND_RTS: begin
                taken  = 1'b1;
                target = it.lr_value;
            end
            KIND_SLEEP: begin
                r.trap_status = TRAP_SLEEP;
                r.end_trace   = 1'b1;
            end
            KIND_RTE: begin
                r.sp_write = 1'b1;
                r.next_sp  = it.saved_sp;
                r.sr_write = 1'b1;
                r.next_sr  = it.saved_sr;
                taken      = 1'b1;
                target     = it.saved_pc;
            end
            KIND_BREAK: begin
                r.trap_status = TRAP_BREAK;
                r.end_trace   = 1'b1;
            end
            KIND_SYNCI: r.flush_request = 1'b1;
            KIND_BRAOT: begin
                r.table_address = it.table_base + it.immediate;
                taken           = 1'b1;
                target          = it.table_word;
            end
            KIND_BSROT: begin
                r.table_address = it.table_base + it.immediate;
                taken           = 1'b1;
                link            = 1'b1;
                target          = it.table_word;
            end
            // nop, synco and every unassigned code leave the result all zero.
            default: ;
        endcase
        if (taken) begin
            r.pc_write  = 1'b1;
            r.next_pc   = target;
            r.end_trace = 1'b1;
        end
        if (link) begin
            r.lr_write = 1'b1;
            r.next_lr  = it.instr_pc + INSTR_BYTES;
        end
        return r;
    endfunction

    // Mostly uniform 64-bit values, with the edges near zero and near the
    // top weighted up so that the wrapping adds are hit often.
    function automatic word_t random_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return word_t'($urandom_range(0, 15));
            3: return '1 - word_t'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        if ($urandom_range(0, 9) == 0) begin
            it.kind = kind_t'($urandom_range(17, 31));
        end else begin
            it.kind = kind_t'($urandom_range(0, 16));
        end
        it.instr_pc   = random_word();
        it.rm_value   = random_word();
        it.immediate  = random_word();
        it.sr_value   = random_word();
        it.lr_value   = random_word();
        it.saved_pc   = random_word();
        it.saved_sr   = random_word();
        it.saved_sp   = random_word();
        it.table_base = random_word();
        it.table_word = random_word();
        return it;
    endfunction

    // Presents one instruction and returns in the time step of the edge that
    // accepted it. Valid is left high, so a following call keeps the channel
    // busy without a bubble; idle_sender, the drain pause and the final wait lower it.
    task automatic issue_instr(instr_t it);
        s_valid      <= 1'b1;
        s_kind       <= it.kind;
        s_instr_pc   <= it.instr_pc;
        s_rm_value   <= it.rm_value;
        s_immediate  <= it.immediate;
        s_sr_value   <= it.sr_value;
        s_lr_value   <= it.lr_value;
        s_saved_pc   <= it.saved_pc;
        s_saved_sr   <= it.saved_sr;
        s_saved_sp   <= it.saved_sp;
        s_table_base <= it.table_base;
        s_table_word <= it.table_word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_branch(it));
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge aclk);
    endtask

    task automatic check_field(string name, word_t want, word_t got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t %s: expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    // Every operation at least once, the value extremes, the wrapping adds, both
    // outcomes of each conditional branch, the barriers and unassigned codes.
    task automatic test_directed_ops();
        instr_t it;
        it = random_instr(); it.kind = KIND_JMP;  it.rm_value = '1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_JMP;  it.rm_value = '0;
        issue_instr(it);
        // The link value wraps past zero.
        it = random_instr(); it.kind = KIND_JSR;  it.instr_pc = '1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_JMPF; it.instr_pc = '1 - 1; it.rm_value = 64'd1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_JSRF; it.instr_pc = '1; it.rm_value = '1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_BRA;  it.immediate = '1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_BRT;  it.sr_value = 64'd1;
        issue_instr(it);
        // Branch on T with T clear falls through.
        it = random_instr(); it.kind = KIND_BRT;  it.sr_value = '1 - 1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_BRF;  it.sr_value = '0;
        issue_instr(it);
        // Branch on not-T with T set falls through.
        it = random_instr(); it.kind = KIND_BRF;  it.sr_value = '1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_TRAP_UD;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_NOP;  it.rm_value = '1; it.immediate = '1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_RTS;  it.lr_value = '1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_SLEEP;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_RTE;
        it.saved_pc = '1; it.saved_sr = '1; it.saved_sp = '1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_RTE;
        it.saved_pc = '0; it.saved_sr = '0; it.saved_sp = '0;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_BREAK;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_SYNCO;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_SYNCI;
        issue_instr(it);
        // The table address wraps around the top of the address space.
        it = random_instr(); it.kind = KIND_BRAOT;
        it.table_base = '1; it.immediate = 64'd1; it.table_word = '1;
        issue_instr(it);
        it = random_instr(); it.kind = KIND_BSROT; it.instr_pc = '1 - 1;
        issue_instr(it);
        it = random_instr(); it.kind = kind_t'(17);
        issue_instr(it);
        it = random_instr(); it.kind = '1;
        issue_instr(it);
    endtask

    // Random instructions with random gaps on the sender side.
    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 5) == 0) idle_sender();
            issue_instr(random_instr());
        end
    endtask

    // A back-to-back burst, then the sender holds off until the pipeline has
    // drained completely before it resumes.
    task automatic test_drain_pause();
        for (int i = 0; i < 30; i++) issue_instr(random_instr());
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        for (int i = 0; i < 30; i++) issue_instr(random_instr());
    endtask

    // No sender gaps; the receiver still stalls, so s_ready must drop and
    // recover with both stages full.
    task automatic test_back_to_back(int count);
        for (int i = 0; i < count; i++) issue_instr(random_instr());
    endtask

    // Final stretch at full rate on both channels.
    task automatic test_steady_stream(int count);
        quiet = 1'b1;
        for (int i = 0; i < count; i++) issue_instr(random_instr());
    endtask

    // The receiver drops m_ready in random bursts, with runs of
    // readiness in between, until the quiet phase begins.
    initial begin : result_ready_driver
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if (!quiet) repeat ($urandom_range(0, 20)) @(posedge aclk);
        end
    end

    // Every result transfer is compared with the oldest prediction.
    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("%0t result transfer with none expected", $time);
            end else begin
                want = pending_results.pop_front();
                check_field("pc_write", word_t'(want.pc_write), word_t'(m_pc_write));
                check_field("next_pc", want.next_pc, m_next_pc);
                check_field("lr_write", word_t'(want.lr_write), word_t'(m_lr_write));
                check_field("next_lr", want.next_lr, m_next_lr);
                check_field("sr_write", word_t'(want.sr_write), word_t'(m_sr_write));
                check_field("next_sr", want.next_sr, m_next_sr);
                check_field("sp_write", word_t'(want.sp_write), word_t'(m_sp_write));
                check_field("next_sp", want.next_sp, m_next_sp);
                check_field("trap_status", word_t'(want.trap_status), word_t'(m_trap_status));
                check_field("flush_request", word_t'(want.flush_request),
                            word_t'(m_flush_request));
                check_field("end_trace", word_t'(want.end_trace), word_t'(m_end_trace));
                check_field("table_address", want.table_address, m_table_address);
            end
        end
    end

    // A hung handshake shows up as a long run of cycles with no transfer.
    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("branch_control_execute_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : test_sequence
        mismatches   = 0;
        idle_cycles  = 0;
        quiet        = 1'b0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_kind       <= KIND_NOP;
        s_instr_pc   <= '0;
        s_rm_value   <= '0;
        s_immediate  <= '0;
        s_sr_value   <= '0;
        s_lr_value   <= '0;
        s_saved_pc   <= '0;
        s_saved_sr   <= '0;
        s_saved_sp   <= '0;
        s_table_base <= '0;
        s_table_word <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_ops();
        test_random_mix(300);
        test_drain_pause();
        test_back_to_back(120);
        test_steady_stream(150);

        // Wait for the last results, then keep watching so that any extra
        // transfer from the two-stage pipeline would still be caught.
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("branch_control_execute_unit: match");
        end else begin
            $display("branch_control_execute_unit: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
